/* design/nearest_palette_color_search_unit_defines.svh */
// Assertion macros shared by the palette search RTL.
// AST_HOLDS checks a same-cycle implication, AST_NEXT a next-cycle one.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define AST_HOLDS(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`define AST_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AST_HOLDS(label, clk, rstn, ante, cons)

`define AST_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

/* design/npcs_pkg.sv */
package npcs_pkg;

  localparam int PaletteEntriesDef = 256;
  localparam int IndexW = 8;
  localparam int CompW  = 8;
  localparam int QueryW = 15;
  localparam int DistW  = 18;
  localparam int DistMax = 190512;

  localparam logic [QueryW-1:0] RedMask   = 15'h001F;
  localparam logic [QueryW-1:0] GreenMask = 15'h03E0;
  localparam logic [QueryW-1:0] BlueMask  = 15'h7C00;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // One word travelling down the cell chain. For a load, index and the
  // components are the entry to write; for a query, the components are the
  // widened color and index/distance the best match so far.
  typedef struct packed {
    op_e               op;
    logic [IndexW-1:0] index;
    logic [CompW-1:0]  red;
    logic [CompW-1:0]  green;
    logic [CompW-1:0]  blue;
    logic [DistW-1:0]  distance;
  } chain_word_t;

  function automatic logic [CompW-1:0] widen5(input logic [4:0] c);
    widen5 = {c, 3'b100};
  endfunction

  function automatic logic [2*CompW-1:0] sq_diff(input logic [CompW-1:0] a,
                                                 input logic [CompW-1:0] b);
    logic [CompW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    sq_diff = d * d;
  endfunction

endpackage

/* design/npcs_cell.sv */
`include "nearest_palette_color_search_unit_defines.svh"

module npcs_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 vld_i,
  input  npcs_pkg::chain_word_t word_i,
  output logic                 vld_o,
  output npcs_pkg::chain_word_t word_o
);

  logic [npcs_pkg::CompW-1:0] ent_r_q, ent_g_q, ent_b_q;
  logic [npcs_pkg::DistW-1:0] cell_dist;
  logic                       hit_load;
  logic                       take;
  logic                       vld_q;
  npcs_pkg::chain_word_t      word_d, word_q;

  assign cell_dist = npcs_pkg::DistW'(npcs_pkg::sq_diff(word_i.red, ent_r_q))
                   + npcs_pkg::DistW'(npcs_pkg::sq_diff(word_i.green, ent_g_q))
                   + npcs_pkg::DistW'(npcs_pkg::sq_diff(word_i.blue, ent_b_q));

  assign hit_load = adv_i && vld_i && (word_i.op == npcs_pkg::OP_LOAD)
                 && (word_i.index == npcs_pkg::IndexW'(CELL_IDX));

  // Strict compare keeps the lower index on a tie.
  assign take = (word_i.op == npcs_pkg::OP_QUERY)
             && ((CELL_IDX == 0) || (cell_dist < word_i.distance));

  always_comb begin
    word_d = word_i;
    if (take) begin
      word_d.index    = npcs_pkg::IndexW'(CELL_IDX);
      word_d.distance = cell_dist;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_load) begin
      ent_r_q <= word_i.red;
      ent_g_q <= word_i.green;
      ent_b_q <= word_i.blue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

  `AST_HOLDS(a_best_idx_upto_cell, clk_i, rst_ni,
             vld_q && (word_q.op == npcs_pkg::OP_QUERY),
             word_q.index <= npcs_pkg::IndexW'(CELL_IDX))

  `AST_NEXT(a_dist_never_grows, clk_i, rst_ni,
            adv_i && vld_i && (word_i.op == npcs_pkg::OP_QUERY) && (CELL_IDX != 0),
            word_q.distance <= $past(word_i.distance))

endmodule

/* design/nearest_palette_color_search_unit.sv */
// Nearest palette color search over a chain of PALETTE_ENTRIES cells.
// A query passes a register in each cell before its result shows on the output.
// Throughput: one load or query word per cycle; the whole chain holds while a
// result waits on a stalled output.
// Reset clears only the valid bits; palette entries hold nothing until loaded.
`include "nearest_palette_color_search_unit_defines.svh"

module nearest_palette_color_search_unit #(
  parameter int PALETTE_ENTRIES = npcs_pkg::PaletteEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [npcs_pkg::IndexW-1:0] entry_index_i,
  input  logic [npcs_pkg::CompW-1:0]  entry_red_i,
  input  logic [npcs_pkg::CompW-1:0]  entry_green_i,
  input  logic [npcs_pkg::CompW-1:0]  entry_blue_i,
  input  logic [npcs_pkg::QueryW-1:0] query_color_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [npcs_pkg::IndexW-1:0] best_index_o,
  output logic [npcs_pkg::DistW-1:0]  best_distance_o
);

  npcs_pkg::chain_word_t in_word;
  npcs_pkg::chain_word_t words [PALETTE_ENTRIES+1];
  logic                  vlds  [PALETTE_ENTRIES+1];
  logic                  adv;
  logic [npcs_pkg::QueryW-1:0] q_r, q_g, q_b;

  assign q_r = query_color_i & npcs_pkg::RedMask;
  assign q_g = (query_color_i & npcs_pkg::GreenMask) >> 5;
  assign q_b = (query_color_i & npcs_pkg::BlueMask) >> 10;

  always_comb begin
    in_word.op       = npcs_pkg::op_e'(operation_i);
    in_word.index    = entry_index_i;
    in_word.distance = '1;
    if (in_word.op == npcs_pkg::OP_QUERY) begin
      in_word.red   = npcs_pkg::widen5(q_r[4:0]);
      in_word.green = npcs_pkg::widen5(q_g[4:0]);
      in_word.blue  = npcs_pkg::widen5(q_b[4:0]);
    end else begin
      in_word.red   = entry_red_i;
      in_word.green = entry_green_i;
      in_word.blue  = entry_blue_i;
    end
  end

  assign words[0] = in_word;
  assign vlds[0]  = in_valid_i;

  // Advance the whole chain unless a finished result is held on the output.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
    npcs_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .vld_i (vlds[g]),
      .word_i(words[g]),
      .vld_o (vlds[g+1]),
      .word_o(words[g+1])
    );
  end

  // Loads drop off the chain end; only queries leave as results.
  assign out_valid_o     = vlds[PALETTE_ENTRIES]
                        && (words[PALETTE_ENTRIES].op == npcs_pkg::OP_QUERY);
  assign best_index_o    = words[PALETTE_ENTRIES].index;
  assign best_distance_o = words[PALETTE_ENTRIES].distance;

  `AST_HOLDS(a_no_stall_when_empty, clk_i, rst_ni,
             !out_valid_o, !in_stall_o)

  `AST_HOLDS(a_dist_in_range, clk_i, rst_ni,
             out_valid_o, best_distance_o <= npcs_pkg::DistW'(npcs_pkg::DistMax))

  `AST_HOLDS(a_index_in_range, clk_i, rst_ni,
             out_valid_o, 32'(best_index_o) < 32'(PALETTE_ENTRIES))

endmodule
